[rtl/ps2mct_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ps2mct_pkg: shared types and constants for the PS/2 cursor tracker
// Field widths, header bit positions, register indexes and the packet phase.
// ----------------------------------------------------------------------------
package ps2mct_pkg;

    // Cursor position width in bits.
    localparam int PosBits = 12;

    localparam int ByteW  = 8;
    localparam int SensW  = 5;
    localparam int SizeW  = 13;
    localparam int BtnW   = 3;
    localparam int ProdW  = ByteW + SensW;
    localparam int CmpW   = (SizeW > PosBits) ? SizeW : PosBits;
    localparam int SumW   = ((PosBits > ProdW) ? PosBits : ProdW) + 2;
    localparam int CfgIdxW = 2;

    localparam logic [PosBits-1:0] PosMax   = '1;
    localparam logic [PosBits-1:0] PosReset = PosBits'(50);
    localparam logic [SizeW-1:0]   CursorSize = SizeW'(16);

    localparam logic [SensW-1:0] SensReset   = SensW'(1);
    localparam logic [SizeW-1:0] WidthReset  = SizeW'(1024);
    localparam logic [SizeW-1:0] HeightReset = SizeW'(768);

    // Header byte bit positions.
    localparam int HdrSync  = 3;
    localparam int HdrXSign = 4;
    localparam int HdrYSign = 5;
    localparam int HdrXOvf  = 6;
    localparam int HdrYOvf  = 7;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] RegSensitivity  = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] RegScreenWidth  = CfgIdxW'(1);
    localparam logic [CfgIdxW-1:0] RegScreenHeight = CfgIdxW'(2);

    localparam int OutFieldW = 2 * PosBits + 3 * BtnW;
    localparam int TdataOutW = ((OutFieldW + 7) / 8) * 8;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_XDATA  = 2'd1,
        PH_YDATA  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [SensW-1:0] sensitivity;
        logic [SizeW-1:0] screen_width;
        logic [SizeW-1:0] screen_height;
    } cfg_t;

    typedef struct packed {
        logic                packet_dropped;
        logic [BtnW-1:0]     hold_flags;
        logic [BtnW-1:0]     click_pulses;
        logic [BtnW-1:0]     buttons_down;
        logic [PosBits-1:0]  cursor_y;
        logic [PosBits-1:0]  cursor_x;
    } result_t;

endpackage
`default_nettype wire

[rtl/ps2mct_in_reg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ps2mct_in_reg: input byte register
// Holds one received byte until the packet core consumes it.
// ----------------------------------------------------------------------------
module ps2mct_in_reg (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [ps2mct_pkg::ByteW-1:0] s_tdata,
    input  wire logic                         take,
    output logic                              byte_valid,
    output logic [ps2mct_pkg::ByteW-1:0]      byte_data
);

    logic                         valid_reg, valid_next;
    logic [ps2mct_pkg::ByteW-1:0] data_reg, data_next;
    logic                         accept;

    // The register frees up in the same cycle the core takes its byte.
    assign s_tready = !valid_reg || take;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (accept) begin
            valid_next = 1'b1;
            data_next  = s_tdata;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule
`default_nettype wire

[rtl/ps2mct_axis_calc.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ps2mct_axis_calc: one axis of cursor movement
// Scales a delta magnitude, applies it to the position and clamps to the screen.
// ----------------------------------------------------------------------------
module ps2mct_axis_calc (
    input  wire logic [ps2mct_pkg::PosBits-1:0] pos,
    input  wire logic [ps2mct_pkg::ByteW-1:0]   mag,
    input  wire logic                           toward_zero,
    input  wire logic [ps2mct_pkg::SensW-1:0]   sens,
    input  wire logic [ps2mct_pkg::SizeW-1:0]   size,
    output logic [ps2mct_pkg::PosBits-1:0]      pos_new
);

    logic [ps2mct_pkg::ProdW-1:0]   prod;
    logic [ps2mct_pkg::SumW-1:0]    base;
    logic [ps2mct_pkg::SumW-1:0]    step;
    logic [ps2mct_pkg::SumW-1:0]    sum;
    logic [ps2mct_pkg::SizeW-1:0]   raw_lim;
    logic [ps2mct_pkg::CmpW-1:0]    wide_lim;
    logic [ps2mct_pkg::PosBits-1:0] lim;

    assign prod = ps2mct_pkg::ProdW'(mag) * ps2mct_pkg::ProdW'(sens);
    assign base = ps2mct_pkg::SumW'(pos);
    assign step = ps2mct_pkg::SumW'(prod);
    assign sum  = toward_zero ? (base - step) : (base + step);

    // The cursor may go no further than one cursor size from the far edge.
    assign raw_lim  = (size >= ps2mct_pkg::CursorSize) ? (size - ps2mct_pkg::CursorSize) : '0;
    assign wide_lim = ps2mct_pkg::CmpW'(raw_lim);

    always_comb begin
        if (wide_lim > ps2mct_pkg::CmpW'(ps2mct_pkg::PosMax)) begin
            lim = ps2mct_pkg::PosMax;
        end else begin
            lim = wide_lim[ps2mct_pkg::PosBits-1:0];
        end

        if (sum[ps2mct_pkg::SumW-1]) begin
            pos_new = '0;
        end else if (sum > ps2mct_pkg::SumW'(lim)) begin
            pos_new = lim;
        end else begin
            pos_new = sum[ps2mct_pkg::PosBits-1:0];
        end
    end

endmodule
`default_nettype wire

[rtl/ps2mct_packet_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ps2mct_packet_core: packet assembly, decode and result register
// Tracks the byte phase, updates cursor and buttons, registers the result.
// ----------------------------------------------------------------------------
module ps2mct_packet_core (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire ps2mct_pkg::cfg_t             cfg,
    input  wire logic                         byte_valid,
    input  wire logic [ps2mct_pkg::ByteW-1:0] byte_data,
    output logic                              take,
    output logic                              res_valid,
    input  wire logic                         res_ready,
    output ps2mct_pkg::result_t               res
);

    ps2mct_pkg::phase_t            phase_reg, phase_next;
    logic [ps2mct_pkg::ByteW-1:0]  first_reg, first_next;
    logic [ps2mct_pkg::ByteW-1:0]  second_reg, second_next;
    logic [ps2mct_pkg::PosBits-1:0] pos_x_reg, pos_x_next;
    logic [ps2mct_pkg::PosBits-1:0] pos_y_reg, pos_y_next;
    logic [ps2mct_pkg::BtnW-1:0]   btn_reg, btn_next;
    logic                          res_valid_reg, res_valid_next;
    ps2mct_pkg::result_t           res_reg, res_next;

    logic                          gives_result;
    logic                          overflow;
    logic [ps2mct_pkg::BtnW-1:0]   cur_btn;
    logic [ps2mct_pkg::ByteW-1:0]  x_mag;
    logic [ps2mct_pkg::ByteW-1:0]  y_mag;
    logic [ps2mct_pkg::PosBits-1:0] x_new;
    logic [ps2mct_pkg::PosBits-1:0] y_new;

    assign gives_result = (phase_reg == ps2mct_pkg::PH_YDATA);

    // Only the third byte produces a result, so only it waits on the output.
    assign take = byte_valid && (!gives_result || !res_valid_reg || res_ready);

    assign overflow = first_reg[ps2mct_pkg::HdrXOvf] || first_reg[ps2mct_pkg::HdrYOvf];
    assign cur_btn  = first_reg[ps2mct_pkg::BtnW-1:0];

    // A sign bit with a zero data byte wraps to a zero delta.
    assign x_mag = first_reg[ps2mct_pkg::HdrXSign] ? (~second_reg + 8'd1) : second_reg;
    assign y_mag = first_reg[ps2mct_pkg::HdrYSign] ? (~byte_data + 8'd1) : byte_data;

    // Mouse Y is upward positive; the screen is downward positive.
    ps2mct_axis_calc u_axis_x (
        .pos         (pos_x_reg),
        .mag         (x_mag),
        .toward_zero (first_reg[ps2mct_pkg::HdrXSign]),
        .sens        (cfg.sensitivity),
        .size        (cfg.screen_width),
        .pos_new     (x_new)
    );

    ps2mct_axis_calc u_axis_y (
        .pos         (pos_y_reg),
        .mag         (y_mag),
        .toward_zero (!first_reg[ps2mct_pkg::HdrYSign]),
        .sens        (cfg.sensitivity),
        .size        (cfg.screen_height),
        .pos_new     (y_new)
    );

    // Next phase.
    always_comb begin
        phase_next = phase_reg;
        if (take) begin
            unique case (phase_reg)
                ps2mct_pkg::PH_HEADER: begin
                    if (byte_data[ps2mct_pkg::HdrSync]) begin
                        phase_next = ps2mct_pkg::PH_XDATA;
                    end
                end
                ps2mct_pkg::PH_XDATA: begin
                    phase_next = ps2mct_pkg::PH_YDATA;
                end
                default: begin
                    phase_next = ps2mct_pkg::PH_HEADER;
                end
            endcase
        end
    end

    // Data path and result.
    always_comb begin
        first_next     = first_reg;
        second_next    = second_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        btn_next       = btn_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !res_ready;

        if (take) begin
            unique case (phase_reg)
                ps2mct_pkg::PH_HEADER: begin
                    if (byte_data[ps2mct_pkg::HdrSync]) begin
                        first_next = byte_data;
                    end
                end
                ps2mct_pkg::PH_XDATA: begin
                    second_next = byte_data;
                end
                ps2mct_pkg::PH_YDATA: begin
                    res_valid_next = 1'b1;
                    if (overflow) begin
                        res_next.cursor_x       = pos_x_reg;
                        res_next.cursor_y       = pos_y_reg;
                        res_next.buttons_down   = btn_reg;
                        res_next.click_pulses   = '0;
                        res_next.hold_flags     = '0;
                        res_next.packet_dropped = 1'b1;
                    end else begin
                        pos_x_next              = x_new;
                        pos_y_next              = y_new;
                        btn_next                = cur_btn;
                        res_next.cursor_x       = x_new;
                        res_next.cursor_y       = y_new;
                        res_next.buttons_down   = cur_btn;
                        res_next.click_pulses   = cur_btn & ~btn_reg;
                        res_next.hold_flags     = cur_btn & btn_reg;
                        res_next.packet_dropped = 1'b0;
                    end
                end
                default: begin
                    first_next = first_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= ps2mct_pkg::PH_HEADER;
            first_reg     <= '0;
            second_reg    <= '0;
            pos_x_reg     <= ps2mct_pkg::PosReset;
            pos_y_reg     <= ps2mct_pkg::PosReset;
            btn_reg       <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            first_reg     <= first_next;
            second_reg    <= second_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            btn_reg       <= btn_next;
            res_valid_reg <= res_valid_next;
        end
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
`default_nettype wire

[rtl/ps2_mouse_packet_cursor_tracker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker: PS/2 mouse packets to cursor position
// Assembles three-byte mouse packets and tracks a clamped screen cursor.
// ----------------------------------------------------------------------------
// Raw PS/2 mouse bytes enter one word per handshake on the slave stream. A
// header byte without its sync bit (bit 3) is discarded, so the block
// realigns itself on the next plausible header. Each completed three-byte
// packet yields exactly one output word: the cursor position after the
// movement, the buttons held, the buttons newly pressed and the buttons held
// since the previous packet. A packet with either overflow bit set is
// discarded; its word carries the unchanged position and latched buttons with
// m_tuser high. Movement is scaled by the sensitivity register, Y is flipped
// so that downward is positive, and each axis is clamped to the screen size
// less sixteen pixels. The block takes one byte per clock cycle unless an
// earlier word still waits in the result register when a third byte is
// due; an accepted byte lands in the input register and is decoded from
// there into the result register, which holds the word. Reset places
// the cursor at (50, 50) with all buttons released. Configuration registers
// should be written only while no packet is in flight.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_tracker (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // Configuration write channel.
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [ps2mct_pkg::CfgIdxW-1:0]        cfg_index,
    input  wire logic [ps2mct_pkg::SizeW-1:0]          cfg_data,
    // Byte stream from the mouse.
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [ps2mct_pkg::ByteW-1:0]          s_tdata,  // [7:0] ps2_byte
    // Result stream.
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // From bit 0: cursor_x, cursor_y, buttons_down, click_pulses, hold_flags, zero fill.
    output logic [ps2mct_pkg::TdataOutW-1:0]           m_tdata,
    output logic [0:0]                                 m_tuser   // [0] packet_dropped
);

    ps2mct_pkg::cfg_t     cfg_reg, cfg_next;
    ps2mct_pkg::result_t  res;
    logic                 take;
    logic                 byte_valid;
    logic [ps2mct_pkg::ByteW-1:0] byte_data;

    // Register writes are always accepted; an index beyond the list is ignored.
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                ps2mct_pkg::RegSensitivity: begin
                    cfg_next.sensitivity = cfg_data[ps2mct_pkg::SensW-1:0];
                end
                ps2mct_pkg::RegScreenWidth: begin
                    cfg_next.screen_width = cfg_data;
                end
                ps2mct_pkg::RegScreenHeight: begin
                    cfg_next.screen_height = cfg_data;
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sensitivity   <= ps2mct_pkg::SensReset;
            cfg_reg.screen_width  <= ps2mct_pkg::WidthReset;
            cfg_reg.screen_height <= ps2mct_pkg::HeightReset;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    ps2mct_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .take       (take),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    ps2mct_packet_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .take       (take),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    // The drop flag says what the word means, so it travels on the side band.
    assign m_tdata = ps2mct_pkg::TdataOutW'({res.hold_flags, res.click_pulses,
                                             res.buttons_down, res.cursor_y,
                                             res.cursor_x});
    assign m_tuser = res.packet_dropped;

endmodule
`default_nettype wire
